// File: rtl/gpfe_pkg.sv
// Shared types, codes and frame command tables for the gamepad poll frame engine.
package gpfe_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned PosW  = 4;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_BYTE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		KIND_POLL       = 2'd0,
		KIND_ENTER_CFG  = 2'd1,
		KIND_SET_ANALOG = 2'd2,
		KIND_EXIT_CFG   = 2'd3
	} frame_kind_t;

	localparam logic [ByteW-1:0] CMD_START   = 8'h01;
	localparam logic [ByteW-1:0] CMD_POLL    = 8'h42;
	localparam logic [ByteW-1:0] CMD_CONFIG  = 8'h43;
	localparam logic [ByteW-1:0] CMD_ANALOG  = 8'h44;
	localparam logic [ByteW-1:0] CMD_LOCK    = 8'h03;
	localparam logic [ByteW-1:0] CMD_PAD     = 8'h5A;
	localparam logic [ByteW-1:0] MODE_MASK   = 8'hF0;
	localparam logic [ByteW-1:0] MODE_ANALOG = 8'h70;

	localparam logic [PosW-1:0] POS_MODE  = 4'd1;
	localparam logic [PosW-1:0] POS_BTN1  = 4'd3;
	localparam logic [PosW-1:0] POS_BTN2  = 4'd4;
	localparam logic [PosW-1:0] POS_RX    = 4'd5;
	localparam logic [PosW-1:0] POS_RY    = 4'd6;
	localparam logic [PosW-1:0] POS_LX    = 4'd7;
	localparam logic [PosW-1:0] POS_LY    = 4'd8;

	// Engine state, carried between the state registers and the step logic
	typedef struct packed {
		logic              active;
		frame_kind_t       kind;
		logic [PosW-1:0]   pos;
		logic [ByteW-1:0]  mode;
		logic [ByteW-1:0]  btn_first;
		logic [ByteW-1:0]  btn_second;
		logic [ByteW-1:0]  rx;
		logic [ByteW-1:0]  ry;
		logic [ByteW-1:0]  lx;
		logic [ByteW-1:0]  ly;
	} eng_state_t;

	// Per-item flags that go into the result register
	typedef struct packed {
		logic [ByteW-1:0] tx;
		logic             select;
		logic             done;
		logic             stray;
	} step_res_t;

	function automatic logic [PosW-1:0] frame_len(input frame_kind_t kind);
		logic [PosW-1:0] len;
		len = (kind == KIND_ENTER_CFG) ? 4'd5 : 4'd9;
		return len;
	endfunction

	function automatic logic [ByteW-1:0] cmd_byte(input frame_kind_t kind,
			input logic [PosW-1:0] pos);
		logic [ByteW-1:0] b;
		b = '0;
		if (pos == 4'd0) begin
			b = CMD_START;
		end else if (pos == 4'd1) begin
			unique case (kind)
				KIND_POLL:       b = CMD_POLL;
				KIND_SET_ANALOG: b = CMD_ANALOG;
				default:         b = CMD_CONFIG;
			endcase
		end else begin
			unique case (kind)
				KIND_ENTER_CFG:  b = (pos == 4'd3) ? CMD_START : '0;
				KIND_SET_ANALOG: b = (pos == 4'd3) ? CMD_START :
					(pos == 4'd4) ? CMD_LOCK : '0;
				KIND_EXIT_CFG:   b = (pos >= 4'd4 && pos <= 4'd8) ? CMD_PAD : '0;
				default:         b = '0;
			endcase
		end
		return b;
	endfunction

endpackage

// File: rtl/gpfe_step.sv
// Next-state and result logic for one start or byte-report item.
module gpfe_step (
	input  gpfe_pkg::eng_state_t  cur,
	input  logic                  action,
	input  gpfe_pkg::frame_kind_t frame_kind,
	input  logic [7:0]            rx_byte,
	output gpfe_pkg::eng_state_t  nxt,
	output gpfe_pkg::step_res_t   res
);
	import gpfe_pkg::*;

	logic [PosW-1:0] pos_inc;
	logic            analog;

	assign pos_inc = cur.pos + 4'd1;
	assign analog  = (cur.mode & MODE_MASK) == MODE_ANALOG;

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (action_t'(action))
			ACT_START: begin
				nxt.active = 1'b1;
				nxt.kind   = frame_kind;
				nxt.pos    = '0;
				res.tx     = CMD_START;
				res.select = 1'b1;
			end
			ACT_BYTE: begin
				if (!cur.active) begin
					res.stray = 1'b1;
				end else begin
					if (cur.kind == KIND_POLL) begin
						if (cur.pos == POS_MODE) begin
							nxt.mode = rx_byte;
						end else if (analog) begin
							case (cur.pos)
								POS_BTN1: nxt.btn_first  = rx_byte;
								POS_BTN2: nxt.btn_second = rx_byte;
								POS_RX:   nxt.rx         = rx_byte;
								POS_RY:   nxt.ry         = rx_byte;
								POS_LX:   nxt.lx         = rx_byte;
								POS_LY:   nxt.ly         = rx_byte;
								default:  ;
							endcase
						end
					end
					if (pos_inc >= frame_len(cur.kind)) begin
						nxt.active = 1'b0;
						nxt.pos    = '0;
						res.done   = 1'b1;
					end else begin
						nxt.pos    = pos_inc;
						res.tx     = cmd_byte(cur.kind, pos_inc);
						res.select = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/gamepad_poll_frame_engine_top.sv
// Top level of the gamepad poll frame engine: input register, step logic, result register.
//
// Usage:
//   Input channel (in_valid/in_ready): action 0 starts a frame of kind frame_kind
//   (poll, enter config, set analog, exit config); action 1 reports one byte
//   exchanged with the controller, with the byte received in rx_byte.
//   Output channel (out_valid/out_ready): one result per input transfer, carrying
//   the next command byte to send, select and end-of-frame flags, the latched
//   device mode and, for analog polls, the button and stick bytes.
// Pipeline and throughput:
//   An item is captured in the input register, then the step logic updates
//   the engine state and loads the result register once that register is free
//   or drains; out_valid rises when the result register is loaded. One item
//   per cycle is sustained while out_ready stays high; the step logic is
//   combinational between the state registers and sets that figure.
// Stall:
//   While out_ready is low the result holds; the input register still takes one
//   item, then in_ready drops until the result register frees.
// Reset:
//   arst_n clears both stage valids and the engine state: no frame active, all
//   latched bytes zero.
module gamepad_poll_frame_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [1:0] frame_kind,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tx_byte,
	output logic       select_active,
	output logic       frame_done,
	output logic [7:0] mode_id,
	output logic       analog_ok,
	output logic [7:0] buttons_first,
	output logic [7:0] buttons_second,
	output logic [7:0] right_x,
	output logic [7:0] right_y,
	output logic [7:0] left_x,
	output logic [7:0] left_y,
	output logic       stray_byte
);
	import gpfe_pkg::*;

	// Input register
	logic        valid_s1;
	logic        action_s1;
	frame_kind_t kind_s1;
	logic [7:0]  rx_s1;

	// Result register and engine state
	logic        valid_s2;
	step_res_t   res_s2;
	eng_state_t  state_q;

	eng_state_t  state_nxt;
	step_res_t   res_nxt;
	logic        advance;

	// Move stage 1 into the result register whenever that register is free or drains
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold payload when nothing is transferred
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			kind_s1   <= frame_kind_t'(frame_kind);
			rx_s1     <= rx_byte;
		end
	end

	gpfe_step u_step (
		.cur        (state_q),
		.action     (action_s1),
		.frame_kind (kind_s1),
		.rx_byte    (rx_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Commit the engine state together with the result it belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	// State only moves with the result register, so it always matches the shown result
	assign out_valid      = valid_s2;
	assign tx_byte        = res_s2.tx;
	assign select_active  = res_s2.select;
	assign frame_done     = res_s2.done;
	assign stray_byte     = res_s2.stray;
	assign mode_id        = state_q.mode;
	assign analog_ok      = (state_q.mode & MODE_MASK) == MODE_ANALOG;
	assign buttons_first  = state_q.btn_first;
	assign buttons_second = state_q.btn_second;
	assign right_x        = state_q.rx;
	assign right_y        = state_q.ry;
	assign left_x         = state_q.lx;
	assign left_y         = state_q.ly;

endmodule

// File: rtl/gpfe_checker.sv
// Port-level assertions for the gamepad poll frame engine, bound to its top level.
module gpfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] tx_byte,
	input logic       select_active,
	input logic       frame_done,
	input logic [7:0] mode_id,
	input logic       analog_ok,
	input logic       stray_byte
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(mode_id))
		else $error("result changed while stalled");

	// Ending a frame drops select and sends nothing
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> !select_active && tx_byte == 8'h00 && !stray_byte)
		else $error("frame end with select or data");

	// A stray report leaves the link idle
	a_stray_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stray_byte |-> !select_active && tx_byte == 8'h00)
		else $error("stray report with select or data");

	// Analog flag tracks the mode nibble
	a_analog: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> analog_ok == (mode_id[7:4] == 4'h7))
		else $error("analog flag disagrees with mode");

endmodule

bind gamepad_poll_frame_engine_top gpfe_checker u_gpfe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.tx_byte       (tx_byte),
	.select_active (select_active),
	.frame_done    (frame_done),
	.mode_id       (mode_id),
	.analog_ok     (analog_ok),
	.stray_byte    (stray_byte)
);

// File: sim/tb.sv
// Self-checking testbench for the gamepad poll frame engine: directed frames, then random traffic.
`timescale 1ns / 100ps

module tb;
	import gpfe_pkg::*;

	localparam int unsigned ITEM_TOTAL  = 950;
	localparam int unsigned QUIET_FROM  = 850;  // no idling on either side past this count
	localparam int unsigned HOLD_AT     = 300;  // item count that triggers the long output stall
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_WAIT  = 8;    // margin for the last result to settle
	localparam int unsigned CYCLE_LIMIT = 400000;

	// One input transfer
	typedef struct packed {
		action_t     act;
		frame_kind_t kind;
		logic [7:0]  rx;
	} pad_item_t;

	// One result transfer, in output port order
	typedef struct packed {
		logic [7:0] tx;
		logic       sel;
		logic       done;
		logic [7:0] mode;
		logic       analog;
		logic [7:0] btn_first;
		logic [7:0] btn_second;
		logic [7:0] right_x;
		logic [7:0] right_y;
		logic [7:0] left_x;
		logic [7:0] left_y;
		logic       stray;
	} pad_res_t;

	// Directed row: stimulus, plus a hand-written result where one is given
	typedef struct packed {
		pad_item_t item;
		logic      fixed;
		pad_res_t  res;
	} dir_row_t;

	// Command bytes sent per frame kind, index 0 first
	localparam logic [7:0] CMD_TAB [4][9] = '{
		'{CMD_START, CMD_POLL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{CMD_START, CMD_CONFIG, 8'h00, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{CMD_START, CMD_ANALOG, 8'h00, CMD_START, CMD_LOCK, 8'h00, 8'h00, 8'h00, 8'h00},
		'{CMD_START, CMD_CONFIG, 8'h00, 8'h00, CMD_PAD, CMD_PAD, CMD_PAD, CMD_PAD, CMD_PAD}
	};
	localparam int unsigned FRAME_LEN [4] = '{9, 5, 9, 9};

	// Byte report right after reset: nothing selected, nothing latched
	localparam pad_res_t RES_STRAY_IDLE = '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 1'b1};
	// Poll start right after reset: first command byte, select goes active
	localparam pad_res_t RES_POLL_OPEN = '{CMD_START, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 1'b0};

	localparam int unsigned DIR_ROWS = 24;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// stray byte report straight out of reset
		'{'{ACT_BYTE,  KIND_POLL,       8'hFF}, 1'b1, RES_STRAY_IDLE},
		// analog poll: mode 0x73, then buttons and axes at the byte extremes
		'{'{ACT_START, KIND_POLL,       8'h00}, 1'b1, RES_POLL_OPEN},
		'{'{ACT_BYTE,  KIND_EXIT_CFG,   8'h00}, 1'b0, '0},  // kind ignored on a report
		'{'{ACT_BYTE,  KIND_POLL,       8'h73}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h5A}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_SET_ANALOG, 8'hFF}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h00}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h80}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_ENTER_CFG,  8'h7F}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h01}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'hFE}, 1'b0, '0},  // frame ends here
		'{'{ACT_BYTE,  KIND_POLL,       8'h55}, 1'b0, '0},  // stray after frame end
		// short enter-config frame
		'{'{ACT_START, KIND_ENTER_CFG,  8'hFF}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'hAA}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h55}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h0F}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'hF0}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h3C}, 1'b0, '0},
		// set-analog cut short by an exit-config start
		'{'{ACT_START, KIND_SET_ANALOG, 8'h00}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h00}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h00}, 1'b0, '0},
		'{'{ACT_START, KIND_EXIT_CFG,   8'h00}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h11}, 1'b0, '0},
		'{'{ACT_BYTE,  KIND_POLL,       8'h22}, 1'b0, '0}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       action;
	logic [1:0] frame_kind;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] tx_byte;
	logic       select_active;
	logic       frame_done;
	logic [7:0] mode_id;
	logic       analog_ok;
	logic [7:0] buttons_first;
	logic [7:0] buttons_second;
	logic [7:0] right_x;
	logic [7:0] right_y;
	logic [7:0] left_x;
	logic [7:0] left_y;
	logic       stray_byte;

	// Predicted engine state
	logic        eng_active;
	frame_kind_t eng_kind;
	logic [3:0]  eng_pos;
	logic [7:0]  eng_mode;
	logic [7:0]  eng_btn_first;
	logic [7:0]  eng_btn_second;
	logic [7:0]  eng_right_x;
	logic [7:0]  eng_right_y;
	logic [7:0]  eng_left_x;
	logic [7:0]  eng_left_y;

	pad_res_t    pending_results[$];
	int unsigned items_sent;
	int unsigned gap_pct;
	int unsigned fail_cnt;
	int unsigned cycle_cnt;
	bit          quiet;
	bit          hold_done;

	gamepad_poll_frame_engine_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.frame_kind    (frame_kind),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tx_byte       (tx_byte),
		.select_active (select_active),
		.frame_done    (frame_done),
		.mode_id       (mode_id),
		.analog_ok     (analog_ok),
		.buttons_first (buttons_first),
		.buttons_second(buttons_second),
		.right_x       (right_x),
		.right_y       (right_y),
		.left_x        (left_x),
		.left_y        (left_y),
		.stray_byte    (stray_byte)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the predicted engine by one transfer and return the result it yields
	task automatic advance_engine(input pad_item_t item, output pad_res_t res);
		logic [3:0] nxt;
		res = '0;
		if (item.act == ACT_START) begin
			// a start always wins, even over a frame in flight
			eng_active = 1'b1;
			eng_kind   = item.kind;
			eng_pos    = '0;
			res.tx     = CMD_TAB[item.kind][0];
		end else if (!eng_active) begin
			res.stray = 1'b1;
		end else begin
			if (eng_kind == KIND_POLL) begin
				if (eng_pos == POS_MODE) begin
					eng_mode = item.rx;
				end else if ((eng_mode & MODE_MASK) == MODE_ANALOG) begin
					// digital mode drops the data bytes and keeps old values
					case (eng_pos)
						POS_BTN1: eng_btn_first  = item.rx;
						POS_BTN2: eng_btn_second = item.rx;
						POS_RX:   eng_right_x    = item.rx;
						POS_RY:   eng_right_y    = item.rx;
						POS_LX:   eng_left_x     = item.rx;
						POS_LY:   eng_left_y     = item.rx;
						default: ;
					endcase
				end
			end
			nxt = eng_pos + 4'd1;
			if (nxt >= FRAME_LEN[eng_kind]) begin
				eng_active = 1'b0;
				eng_pos    = '0;
				res.done   = 1'b1;
			end else begin
				eng_pos = nxt;
				res.tx  = CMD_TAB[eng_kind][nxt];
			end
		end
		res.sel        = eng_active;
		res.mode       = eng_mode;
		res.analog     = ((eng_mode & MODE_MASK) == MODE_ANALOG);
		res.btn_first  = eng_btn_first;
		res.btn_second = eng_btn_second;
		res.right_x    = eng_right_x;
		res.right_y    = eng_right_y;
		res.left_x     = eng_left_x;
		res.left_y     = eng_left_y;
	endtask

	// Offer one item from a falling edge, hold it until the transfer, return at a falling edge
	task automatic put_item(input pad_item_t item, input logic fixed, input pad_res_t fixed_res);
		int unsigned gap;
		pad_res_t    pred;
		if (!quiet && ($urandom_range(0, 99) < gap_pct)) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		action     <= item.act;
		frame_kind <= item.kind;
		rx_byte    <= item.rx;
		do @(posedge clk); while (!in_ready);
		advance_engine(item, pred);
		pending_results.push_back(fixed ? fixed_res : pred);
		items_sent++;
		quiet = (items_sent >= QUIET_FROM);
		@(negedge clk);
	endtask

	task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			fail_cnt++;
			$error("%s: expected %0h, actual %0h", name, want, got);
		end
	endtask

	// Check every result transfer against the oldest prediction
	always @(posedge clk) begin : result_check
		pad_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				fail_cnt++;
				$error("result transfer with no prediction waiting: tx_byte %0h", tx_byte);
			end else begin
				want = pending_results.pop_front();
				cmp_field("tx_byte",        want.tx,         tx_byte);
				cmp_field("select_active",  8'(want.sel),    8'(select_active));
				cmp_field("frame_done",     8'(want.done),   8'(frame_done));
				cmp_field("mode_id",        want.mode,       mode_id);
				cmp_field("analog_ok",      8'(want.analog), 8'(analog_ok));
				cmp_field("buttons_first",  want.btn_first,  buttons_first);
				cmp_field("buttons_second", want.btn_second, buttons_second);
				cmp_field("right_x",        want.right_x,    right_x);
				cmp_field("right_y",        want.right_y,    right_y);
				cmp_field("left_x",         want.left_x,     left_x);
				cmp_field("left_y",         want.left_y,     left_y);
				cmp_field("stray_byte",     8'(want.stray),  8'(stray_byte));
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("gamepad_poll_frame_engine_top regression: fail");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off so the block backs up into
	// its input, then always ready once the quiet tail starts
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && items_sent >= HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Sender: directed table first, then random frames
	initial begin : stimulus
		pad_item_t   start_item;
		pad_item_t   byte_item;
		int unsigned dice;
		int unsigned nbytes;
		int unsigned row;

		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		action     = 1'b0;
		frame_kind = 2'd0;
		rx_byte    = 8'd0;
		items_sent = 0;
		gap_pct    = 20;
		fail_cnt   = 0;
		cycle_cnt  = 0;
		quiet      = 1'b0;
		hold_done  = 1'b0;

		// Mirror the reset state in the predictor
		eng_active     = 1'b0;
		eng_kind       = KIND_POLL;
		eng_pos        = '0;
		eng_mode       = '0;
		eng_btn_first  = '0;
		eng_btn_second = '0;
		eng_right_x    = '0;
		eng_right_y    = '0;
		eng_left_x     = '0;
		eng_left_y     = '0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < DIR_ROWS; row++)
			put_item(DIR_TAB[row].item, DIR_TAB[row].fixed, DIR_TAB[row].res);

		while (items_sent < ITEM_TOTAL) begin
			// vary idle density per frame: some frames run back to back
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 50;
			endcase
			dice = $urandom_range(0, 99);
			if (dice < 8) begin
				// noise: any action, any kind, any byte
				byte_item.act  = action_t'($urandom_range(0, 1));
				byte_item.kind = frame_kind_t'($urandom_range(0, 3));
				byte_item.rx   = 8'($urandom);
				put_item(byte_item, 1'b0, '0);
			end else begin
				start_item.act  = ACT_START;
				start_item.kind = frame_kind_t'($urandom_range(0, 3));
				start_item.rx   = 8'($urandom);
				put_item(start_item, 1'b0, '0);
				nbytes = FRAME_LEN[start_item.kind];
				// cut some frames short; the next start abandons them
				if ($urandom_range(0, 9) == 0)
					nbytes = $urandom_range(0, nbytes - 1);
				for (int unsigned i = 0; i < nbytes; i++) begin
					byte_item.act  = ACT_BYTE;
					byte_item.kind = frame_kind_t'($urandom_range(0, 3));
					byte_item.rx   = 8'($urandom);
					// favor an analog mode byte so the data latches get exercised
					if (i == POS_MODE && $urandom_range(0, 9) < 6)
						byte_item.rx = {4'h7, 4'($urandom_range(0, 15))};
					put_item(byte_item, 1'b0, '0);
				end
				if ($urandom_range(0, 6) == 0) begin
					byte_item.act  = ACT_BYTE;
					byte_item.kind = frame_kind_t'($urandom_range(0, 3));
					byte_item.rx   = 8'($urandom);
					put_item(byte_item, 1'b0, '0);
				end
			end
		end
		in_valid <= 1'b0;

		// Drain: wait for every predicted result, then let the pipeline settle
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_cnt == 0)
			$display("gamepad_poll_frame_engine_top regression: pass");
		else
			$display("gamepad_poll_frame_engine_top regression: fail");
		$finish;
	end

endmodule
